/* sv/swt_pkg.sv */
// shared types, constants and command/status structs of the software timer bank
package swt_pkg;

  localparam int NUM_TIMERS  = 8;
  localparam int COUNT_WIDTH = 32;
  localparam int MAX_EVENTS  = 8;
  localparam int IDX_W       = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int EVC_W       = $clog2(MAX_EVENTS + 1);

  typedef logic [COUNT_WIDTH-1:0] count_t;

  typedef enum logic [2:0] {
    FN_INIT    = 3'd0,
    FN_START   = 3'd1,
    FN_STOP    = 3'd2,
    FN_TICK    = 3'd3,
    FN_DESTROY = 3'd4,
    FN_QUERY   = 3'd5
  } func_t;

  typedef enum logic [2:0] {
    ST_UNUSED    = 3'd0,
    ST_CREATED   = 3'd1,
    ST_STARTED   = 3'd2,
    ST_STOPPED   = 3'd3,
    ST_DESTROYED = 3'd4
  } timer_state_t;

  typedef enum logic {
    KIND_ACK  = 1'b0,
    KIND_FIRE = 1'b1
  } kind_t;

  typedef struct packed {
    logic load;
    logic scan_clear;
    logic apply_op;
    logic scan_step;
    logic flush_push;
  } swt_cmd_t;

  typedef struct packed {
    logic in_tick;
    logic in_bad;
    logic out_free;
    logic pend_valid;
    logic scan_last;
  } swt_status_t;

endpackage

/* sv/swt_ctrl.sv */
// controller state machine of the software timer bank
module swt_ctrl import swt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  swt_status_t status,
  output swt_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_OP    = 4'b0010,
    S_SCAN  = 4'b0100,
    S_FLUSH = 4'b1000
  } ctrl_state_t;

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall       = 1'b0;
        cmd.load       = in_valid;
        cmd.scan_clear = in_valid;
        if (in_valid && !status.in_bad) begin
          state_next = status.in_tick ? S_SCAN : S_OP;
        end
      end
      S_OP: begin
        if (status.out_free) begin
          cmd.apply_op = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_SCAN: begin
        if (!status.pend_valid || status.out_free) begin
          cmd.scan_step = 1'b1;
          if (status.scan_last) begin
            state_next = S_FLUSH;
          end
        end
      end
      S_FLUSH: begin
        if (!status.pend_valid) begin
          state_next = S_IDLE;
        end else if (status.out_free) begin
          cmd.flush_push = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* sv/swt_datapath.sv */
// timer stores, tick scan, pending event and output register
module swt_datapath import swt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  swt_cmd_t    cmd,
  output swt_status_t status,
  input  logic [2:0]  func,
  input  logic [2:0]  timer_id,
  input  logic [31:0] delay_ticks,
  input  logic [31:0] period_ticks,
  input  logic        hard_class,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        kind,
  output logic [2:0]  event_timer,
  output logic [2:0]  timer_state,
  output logic [31:0] start_delay,
  output logic [31:0] period,
  output logic        is_hard,
  output logic        last
);

  count_t       delay_store     [NUM_TIMERS];
  count_t       period_store    [NUM_TIMERS];
  count_t       remaining_count [NUM_TIMERS];
  timer_state_t state_store     [NUM_TIMERS];
  logic         class_store     [NUM_TIMERS];

  // latched operation
  func_t       op_func;
  logic [2:0]  op_id;
  count_t      op_delay;
  count_t      op_period;
  logic        op_hard;

  // scan position
  logic [IDX_W-1:0] scan_idx;
  logic             scan_hard;
  logic [EVC_W-1:0] ev_count;

  // pending fire event
  logic         pend_valid;
  logic [2:0]   pend_timer;
  timer_state_t pend_state;
  count_t       pend_delay;
  count_t       pend_period;
  logic         pend_hard;

  logic out_free;

  // operation side
  logic             op_in_range;
  logic [IDX_W-1:0] op_idx;
  timer_state_t     cur_state;
  timer_state_t     new_state;
  count_t           new_delay;
  count_t           new_period;
  logic             new_hard;
  count_t           new_rem;
  logic             op_write;

  // scan side
  timer_state_t s_state;
  count_t       s_rem;
  count_t       s_per;
  logic         s_match;
  logic         s_fire;
  logic         s_record;
  count_t       s_new_rem;
  timer_state_t s_new_state;
  logic         push_pend;

  assign out_free = !out_valid || !out_stall;

  assign status.in_tick    = (func == FN_TICK);
  assign status.in_bad     = (func > FN_QUERY);
  assign status.out_free   = out_free;
  assign status.pend_valid = pend_valid;
  assign status.scan_last  = !scan_hard && (scan_idx == IDX_W'(NUM_TIMERS - 1));

  assign op_in_range = (int'(op_id) < NUM_TIMERS);
  assign op_idx      = IDX_W'(op_id);
  assign cur_state   = state_store[op_idx];

  always_comb begin
    new_state  = cur_state;
    new_delay  = delay_store[op_idx];
    new_period = period_store[op_idx];
    new_hard   = class_store[op_idx];
    new_rem    = remaining_count[op_idx];
    op_write   = 1'b0;
    unique case (op_func)
      FN_INIT: begin
        op_write   = 1'b1;
        new_state  = ST_CREATED;
        new_delay  = op_delay;
        new_period = op_period;
        new_hard   = op_hard;
        new_rem    = (op_delay != '0) ? op_delay : op_period;
      end
      FN_START: begin
        if (cur_state == ST_CREATED || cur_state == ST_STOPPED) begin
          op_write  = 1'b1;
          new_state = ST_STARTED;
          new_rem   = (new_delay != '0) ? new_delay : new_period;
        end
      end
      FN_STOP: begin
        if (cur_state == ST_STARTED) begin
          op_write  = 1'b1;
          new_state = ST_STOPPED;
        end
      end
      FN_DESTROY: begin
        op_write  = 1'b1;
        new_state = ST_DESTROYED;
      end
      default: begin
        op_write = 1'b0;
      end
    endcase
  end

  assign s_state = state_store[scan_idx];
  assign s_rem   = remaining_count[scan_idx];
  assign s_per   = period_store[scan_idx];
  assign s_match = (s_state == ST_STARTED) && (class_store[scan_idx] == scan_hard);
  assign s_fire  = s_match && (s_rem == count_t'(0) || s_rem == count_t'(1));
  assign s_record = s_fire && (ev_count < EVC_W'(MAX_EVENTS));

  always_comb begin
    s_new_rem   = (s_rem == '0) ? s_rem : s_rem - count_t'(1);
    s_new_state = s_state;
    if (s_fire) begin
      if (s_per != '0) begin
        s_new_rem = s_per;
      end else begin
        s_new_state = ST_STOPPED;
      end
    end
  end

  assign push_pend = cmd.scan_step && s_record && pend_valid;

  // stores
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_TIMERS; i++) begin
        delay_store[i]     <= '0;
        period_store[i]    <= '0;
        remaining_count[i] <= '0;
        state_store[i]     <= ST_UNUSED;
        class_store[i]     <= 1'b0;
      end
    end else if (cmd.apply_op && op_in_range && op_write) begin
      delay_store[op_idx]     <= new_delay;
      period_store[op_idx]    <= new_period;
      remaining_count[op_idx] <= new_rem;
      state_store[op_idx]     <= new_state;
      class_store[op_idx]     <= new_hard;
    end else if (cmd.scan_step && s_match) begin
      remaining_count[scan_idx] <= s_new_rem;
      state_store[scan_idx]     <= s_new_state;
    end
  end

  // operation latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_func   <= func_t'(func);
      op_id     <= timer_id;
      op_delay  <= count_t'(delay_ticks);
      op_period <= count_t'(period_ticks);
      op_hard   <= hard_class;
    end
  end

  // scan counters
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx  <= '0;
      scan_hard <= 1'b1;
      ev_count  <= '0;
    end else if (cmd.scan_clear) begin
      scan_idx  <= '0;
      scan_hard <= 1'b1;
      ev_count  <= '0;
    end else if (cmd.scan_step) begin
      if (s_record) begin
        ev_count <= ev_count + EVC_W'(1);
      end
      if (scan_idx == IDX_W'(NUM_TIMERS - 1)) begin
        scan_idx  <= '0;
        scan_hard <= 1'b0;
      end else begin
        scan_idx <= scan_idx + IDX_W'(1);
      end
    end
  end

  // pending event
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (cmd.scan_step && s_record) begin
      pend_valid <= 1'b1;
    end else if (cmd.flush_push) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step && s_record) begin
      pend_timer  <= 3'(scan_idx);
      pend_state  <= s_new_state;
      pend_delay  <= delay_store[scan_idx];
      pend_period <= s_per;
      pend_hard   <= scan_hard;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.apply_op || push_pend || cmd.flush_push) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply_op) begin
      kind        <= KIND_ACK;
      event_timer <= op_id;
      last        <= 1'b1;
      if (op_in_range) begin
        timer_state <= new_state;
        start_delay <= 32'(new_delay);
        period      <= 32'(new_period);
        is_hard     <= new_hard;
      end else begin
        timer_state <= ST_UNUSED;
        start_delay <= '0;
        period      <= '0;
        is_hard     <= 1'b0;
      end
    end else if (push_pend || cmd.flush_push) begin
      kind        <= KIND_FIRE;
      event_timer <= pend_timer;
      timer_state <= pend_state;
      start_delay <= 32'(pend_delay);
      period      <= 32'(pend_period);
      is_hard     <= pend_hard;
      last        <= cmd.flush_push;
    end
  end

endmodule

/* sv/software_timer_bank.sv */
// top level of the software timer bank: controller plus datapath
// an operation is latched at its transfer, and its result is written to the output register once the output is free
// a tick scans hard then soft timers, one entry per cycle while no output stall holds the scan
// a new operation or tick is taken only in idle, after the previous one has finished
// output stalls hold the scan while a fire event waits for the output register
// synchronous reset clears all timers to unused with zero delay, period and count
module software_timer_bank import swt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  func,
  input  logic [2:0]  timer_id,
  input  logic [31:0] delay_ticks,
  input  logic [31:0] period_ticks,
  input  logic        hard_class,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        kind,
  output logic [2:0]  event_timer,
  output logic [2:0]  timer_state,
  output logic [31:0] start_delay,
  output logic [31:0] period,
  output logic        is_hard,
  output logic        last
);

  swt_cmd_t    cmd;
  swt_status_t status;

  swt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  swt_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .func         (func),
    .timer_id     (timer_id),
    .delay_ticks  (delay_ticks),
    .period_ticks (period_ticks),
    .hard_class   (hard_class),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .event_timer  (event_timer),
    .timer_state  (timer_state),
    .start_delay  (start_delay),
    .period       (period),
    .is_hard      (is_hard),
    .last         (last)
  );

endmodule
